// ===== rtl/m2m_pkg.sv =====
`default_nettype none

package m2m_pkg;

  // fixed width of the delay field on the result port
  localparam int unsigned DelayOutW = 28;

  // parser phase
  typedef enum logic [1:0] {
    PH_EVENT = 2'd0,
    PH_DATA1 = 2'd1,
    PH_DATA2 = 2'd2,
    PH_DELAY = 2'd3
  } phase_e;

  // result kind codes
  typedef enum logic [1:0] {
    RK_MIDI  = 2'd0,
    RK_END   = 2'd1,
    RK_ERROR = 2'd2
  } result_kind_e;

  // mus event kinds
  localparam logic [2:0] EV_RELEASE = 3'd0;
  localparam logic [2:0] EV_PLAY    = 3'd1;
  localparam logic [2:0] EV_BEND    = 3'd2;
  localparam logic [2:0] EV_SYSTEM  = 3'd3;
  localparam logic [2:0] EV_CTRL    = 3'd4;
  localparam logic [2:0] EV_END_MIN = 3'd5;

  // midi status nibbles
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CTRL     = 4'hB;
  localparam logic [3:0] ST_PROGRAM  = 4'hC;
  localparam logic [3:0] ST_BEND     = 4'hE;

  localparam logic [7:0] VolumeReset = 8'd127;
  localparam logic [7:0] ProgramData = 8'd64;

  // mus channels swapped with each other
  localparam logic [3:0] ChPerc = 4'd15;
  localparam logic [3:0] ChMusPerc = 4'd9;

  // system event codes 10..14 to midi controller numbers
  function automatic logic [7:0] sys_map(input logic [7:0] code);
    logic [7:0] r;
    unique case (code)
      8'd10:   r = 8'd120;
      8'd11:   r = 8'd123;
      8'd12:   r = 8'd126;
      8'd13:   r = 8'd127;
      8'd14:   r = 8'd121;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // mus controller index 1..9 to midi controller number
  function automatic logic [7:0] ctl_map(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd2:    r = 8'd1;
      4'd3:    r = 8'd7;
      4'd4:    r = 8'd10;
      4'd5:    r = 8'd11;
      4'd6:    r = 8'd91;
      4'd7:    r = 8'd93;
      4'd8:    r = 8'd64;
      4'd9:    r = 8'd67;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mus_to_midi_stream_converter.sv =====
`default_nettype none

// MUS score to MIDI short-message converter. Score bytes enter one per beat
// on the input channel; every complete event leaves as one result beat that
// carries the MIDI status and data bytes together with the delay that came
// before the event (saturated at 2^DELAY_BITS - 1, shown on 28 bits). MUS
// channels 9 and 15 are swapped. A byte with song_start high clears the
// parser, the delay and the 16 channel volumes (back to 127) before it is
// parsed. After an end-of-score result all bytes are dropped until the next
// song_start. The block takes one byte every cycle unless the input stalls;
// a byte is parsed from the input register and a completed event is written
// to the result register. The input stalls only while the result register
// is full and stalled and the registered byte would complete an event.
module mus_to_midi_stream_converter
  import m2m_pkg::*;
#(
  parameter int unsigned DELAY_BITS = 28
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // score byte channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  score_byte_i,
  input  wire logic        song_start_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [27:0]      delay_ticks_o,
  output logic [7:0]       status_byte_o,
  output logic [7:0]       data_one_o,
  output logic [7:0]       data_two_o
);

  localparam int unsigned AccW = DELAY_BITS + 7;
  localparam int unsigned ExtW = DELAY_BITS + DelayOutW;

  // input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       start_q;

  // parser state
  phase_e                phase_q, phase_d;
  logic [2:0]            kind_q, kind_d;
  logic [3:0]            chan_q, chan_d;
  logic [7:0]            held_q, held_d;
  logic                  follows_q, follows_d;
  logic [DELAY_BITS-1:0] accum_q, accum_d;
  logic [DELAY_BITS-1:0] pend_q, pend_d;
  logic                  done_q, done_d;
  logic [7:0]            vol_q [16];

  // result register
  logic                  out_valid_q;
  result_kind_e          res_kind_q, res_kind_d;
  logic [DelayOutW-1:0]  res_delay_q, res_delay_d;
  logic [7:0]            res_status_q, res_status_d;
  logic [7:0]            res_d1_q, res_d1_d;
  logic [7:0]            res_d2_q, res_d2_d;

  // effective state after an optional song start
  phase_e                st_phase;
  logic [2:0]            st_kind;
  logic [3:0]            st_chan;
  logic [7:0]            st_held;
  logic                  st_follows;
  logic [DELAY_BITS-1:0] st_accum;
  logic [DELAY_BITS-1:0] st_pend;
  logic                  st_done;
  logic [7:0]            st_vol;

  logic                  emit;
  logic                  vol_we;
  logic                  out_free;
  logic                  proc;
  logic                  in_accept;
  logic [3:0]            ev_chan;
  logic [AccW-1:0]       acc_shift;
  logic [ExtW-1:0]       pend_ext;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign proc      = in_valid_q && (out_free || !emit);
  assign in_stall_o = in_valid_q && !proc;
  assign in_accept = in_valid_i && !in_stall_o;

  // song start clears everything before the byte is parsed
  always_comb begin
    st_phase   = start_q ? PH_EVENT : phase_q;
    st_kind    = start_q ? 3'd0 : kind_q;
    st_chan    = start_q ? 4'd0 : chan_q;
    st_held    = start_q ? 8'd0 : held_q;
    st_follows = start_q ? 1'b0 : follows_q;
    st_accum   = start_q ? '0 : accum_q;
    st_pend    = start_q ? '0 : pend_q;
    st_done    = start_q ? 1'b0 : done_q;
    st_vol     = start_q ? VolumeReset : vol_q[st_chan];
  end

  // channel swap of the event byte
  always_comb begin
    priority if (byte_q[3:0] == ChMusPerc) begin
      ev_chan = ChPerc;
    end else if (byte_q[3:0] == ChPerc) begin
      ev_chan = ChMusPerc;
    end else begin
      ev_chan = byte_q[3:0];
    end
  end

  assign acc_shift = {st_accum, byte_q[6:0]};
  assign pend_ext  = ExtW'(st_pend);

  // byte parser
  always_comb begin
    phase_d      = st_phase;
    kind_d       = st_kind;
    chan_d       = st_chan;
    held_d       = st_held;
    follows_d    = st_follows;
    accum_d      = st_accum;
    pend_d       = st_pend;
    done_d       = st_done;
    emit         = 1'b0;
    vol_we       = 1'b0;
    res_kind_d   = RK_MIDI;
    res_delay_d  = pend_ext[DelayOutW-1:0];
    res_status_d = 8'd0;
    res_d1_d     = 8'd0;
    res_d2_d     = 8'd0;

    if (!st_done) begin
      unique case (st_phase)
        PH_EVENT: begin
          chan_d    = ev_chan;
          kind_d    = byte_q[6:4];
          follows_d = byte_q[7];
          if (byte_q[6:4] >= EV_END_MIN) begin
            done_d     = 1'b1;
            emit       = 1'b1;
            res_kind_d = RK_END;
            pend_d     = '0;
          end else begin
            phase_d = PH_DATA1;
          end
        end
        PH_DATA1: begin
          unique case (st_kind)
            EV_RELEASE: begin
              emit         = 1'b1;
              res_status_d = {ST_NOTE_OFF, st_chan};
              res_d1_d     = {1'b0, byte_q[6:0]};
              res_d2_d     = st_vol;
            end
            EV_PLAY: begin
              if (byte_q[7]) begin
                held_d  = byte_q;
                phase_d = PH_DATA2;
              end else begin
                emit         = 1'b1;
                res_status_d = {ST_NOTE_ON, st_chan};
                res_d1_d     = {1'b0, byte_q[6:0]};
                res_d2_d     = st_vol;
              end
            end
            EV_BEND: begin
              emit         = 1'b1;
              res_status_d = {ST_BEND, st_chan};
              res_d1_d     = {1'b0, byte_q[0], 6'd0};
              res_d2_d     = {1'b0, byte_q[7:1]};
            end
            EV_SYSTEM: begin
              emit         = 1'b1;
              res_status_d = {ST_CTRL, st_chan};
              if (byte_q >= 8'd10 && byte_q <= 8'd14) begin
                res_d1_d = sys_map(byte_q);
              end else begin
                res_kind_d = RK_ERROR;
                res_d1_d   = byte_q;
              end
            end
            default: begin
              held_d  = byte_q;
              phase_d = PH_DATA2;
            end
          endcase
        end
        PH_DATA2: begin
          emit = 1'b1;
          priority if (st_kind == EV_PLAY) begin
            vol_we       = 1'b1;
            res_status_d = {ST_NOTE_ON, st_chan};
            res_d1_d     = {1'b0, st_held[6:0]};
            res_d2_d     = byte_q;
          end else if (st_held == 8'd0) begin
            res_status_d = {ST_PROGRAM, st_chan};
            res_d1_d     = byte_q;
            res_d2_d     = ProgramData;
          end else if (st_held < 8'd10) begin
            res_status_d = {ST_CTRL, st_chan};
            res_d1_d     = ctl_map(st_held[3:0]);
            res_d2_d     = byte_q;
          end else begin
            res_kind_d   = RK_ERROR;
            res_status_d = {ST_CTRL, st_chan};
            res_d1_d     = st_held;
          end
        end
        PH_DELAY: begin
          // base-128 big-endian delay, saturating
          if (|acc_shift[AccW-1:DELAY_BITS]) begin
            accum_d = '1;
          end else begin
            accum_d = acc_shift[DELAY_BITS-1:0];
          end
          if (!byte_q[7]) begin
            pend_d  = accum_d;
            phase_d = PH_EVENT;
          end
        end
        default: begin
          phase_d = PH_EVENT;
        end
      endcase

      // a message consumes the pending delay and may open a delay field
      if (emit && res_kind_d != RK_END) begin
        pend_d = '0;
        if (st_follows) begin
          accum_d = '0;
          phase_d = PH_DELAY;
        end else begin
          phase_d = PH_EVENT;
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q  <= score_byte_i;
      start_q <= song_start_i;
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_EVENT;
      kind_q    <= 3'd0;
      chan_q    <= 4'd0;
      held_q    <= 8'd0;
      follows_q <= 1'b0;
      accum_q   <= '0;
      pend_q    <= '0;
      done_q    <= 1'b0;
    end else if (proc) begin
      phase_q   <= phase_d;
      kind_q    <= kind_d;
      chan_q    <= chan_d;
      held_q    <= held_d;
      follows_q <= follows_d;
      accum_q   <= accum_d;
      pend_q    <= pend_d;
      done_q    <= done_d;
    end
  end

  // channel volume store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        vol_q[i] <= VolumeReset;
      end
    end else if (proc) begin
      for (int i = 0; i < 16; i++) begin
        if (vol_we && st_chan == 4'(i)) begin
          vol_q[i] <= byte_q;
        end else if (start_q) begin
          vol_q[i] <= VolumeReset;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && emit) begin
      res_kind_q   <= res_kind_d;
      res_delay_q  <= res_delay_d;
      res_status_q <= res_status_d;
      res_d1_q     <= res_d1_d;
      res_d2_q     <= res_d2_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = res_kind_q;
  assign delay_ticks_o = res_delay_q;
  assign status_byte_o = res_status_q;
  assign data_one_o    = res_d1_q;
  assign data_two_o    = res_d2_q;

endmodule

`default_nettype wire
